[hdl/sst_pkg.sv]
package sst_pkg;

    // configuration register file
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int CFG_IDX_W = 4;

    localparam logic [REG_IDX_W-1:0] REG_END    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VALUE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NAME   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COLUMN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STDOUT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STDERR = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ENVIR  = 3'd7;

    typedef logic [NUM_REGS-1:0][7:0] codes_t;

    // entry 0 sits in the lowest byte
    localparam codes_t CODES_RESET = {8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1};

    typedef enum logic [2:0] {
        CLS_DATA,
        CLS_END,
        CLS_VALUE,
        CLS_NAME,
        CLS_COLUMN,
        CLS_STREAM,
        CLS_UNKNOWN
    } byte_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic [1:0]  stream;
    } dec_t;

    // event kinds
    localparam logic [2:0] EV_DATA    = 3'd0;
    localparam logic [2:0] EV_END     = 3'd1;
    localparam logic [2:0] EV_VALUE   = 3'd2;
    localparam logic [2:0] EV_NAME    = 3'd3;
    localparam logic [2:0] EV_COLUMN  = 3'd4;
    localparam logic [2:0] EV_STREAM  = 3'd5;
    localparam logic [2:0] EV_IGNORED = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_FIELDS  = 3'd1;
    localparam logic [2:0] ERR_NAMES   = 3'd2;
    localparam logic [2:0] ERR_COLUMNS = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN = 3'd4;
    localparam logic [2:0] ERR_TARGET  = 3'd5;

    localparam logic [2:0] NO_STREAM = 3'd4;

    localparam int TDATA_OUT_W = 80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  event_kind;
        logic [2:0]  cur_stream;
        logic [6:0]  cur_column;
        logic [7:0]  cur_field;
        logic [7:0]  cur_name;
        logic [16:0] text_offset;
        logic [6:0]  value_count;
        logic [6:0]  name_count;
        logic [6:0]  stream_columns;
        logic [2:0]  error_code;
        logic        out_last;
    } res_t;

endpackage

[hdl/sst_cfg.sv]
module sst_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    output sst_pkg::codes_t               codes
);

    sst_pkg::codes_t codes_reg;
    sst_pkg::codes_t codes_next;

    assign cfg_ready = 1'b1;
    assign codes     = codes_reg;

    // indexes beyond the register list are dropped
    always_comb begin
        codes_next = codes_reg;
        if (cfg_valid && (cfg_index < sst_pkg::CFG_IDX_W'(sst_pkg::NUM_REGS))) begin
            codes_next[cfg_index[sst_pkg::REG_IDX_W-1:0]] = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg <= sst_pkg::CODES_RESET;
        end else begin
            codes_reg <= codes_next;
        end
    end

endmodule

[hdl/sst_decode.sv]
module sst_decode (
    input  logic [7:0]      in_byte,
    input  sst_pkg::codes_t codes,
    output sst_pkg::dec_t   dec
);

    logic                          hit;
    logic [sst_pkg::REG_IDX_W-1:0] idx;

    // lowest register index wins when codes collide
    always_comb begin
        hit = 1'b0;
        idx = '0;
        for (int i = sst_pkg::NUM_REGS - 1; i >= 0; i--) begin
            if (codes[i] == in_byte) begin
                hit = 1'b1;
                idx = sst_pkg::REG_IDX_W'(i);
            end
        end
    end

    always_comb begin
        dec.stream = 2'(idx - sst_pkg::REG_STDOUT);
        if (!hit) begin
            if ((in_byte >= codes[sst_pkg::REG_END]) && (in_byte <= codes[sst_pkg::REG_ENVIR])) begin
                dec.cls = sst_pkg::CLS_UNKNOWN;
            end else begin
                dec.cls = sst_pkg::CLS_DATA;
            end
        end else begin
            case (idx)
                sst_pkg::REG_END:    dec.cls = sst_pkg::CLS_END;
                sst_pkg::REG_VALUE:  dec.cls = sst_pkg::CLS_VALUE;
                sst_pkg::REG_NAME:   dec.cls = sst_pkg::CLS_NAME;
                sst_pkg::REG_COLUMN: dec.cls = sst_pkg::CLS_COLUMN;
                default:             dec.cls = sst_pkg::CLS_STREAM;
            endcase
        end
    end

endmodule

[hdl/sst_track.sv]
module sst_track #(
    parameter int MAX_FIELDS       = 64,
    parameter int MAX_COLUMNS      = 64,
    parameter int MAX_BUFFER_BYTES = 65536
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  sst_pkg::item_t item,
    input  sst_pkg::dec_t  dec,
    output sst_pkg::res_t  res
);

    localparam int CW = $clog2(MAX_COLUMNS) + 1;
    localparam int FW = $clog2(MAX_FIELDS + 1) + 1;
    localparam int NW = $clog2(MAX_FIELDS + 1);
    localparam int SW = $clog2(MAX_COLUMNS + 1);
    localparam int PW = $clog2(MAX_BUFFER_BYTES + 1);

    logic [2:0]           stream_reg,    stream_next;
    logic signed [CW-1:0] column_reg,    column_next;
    logic signed [FW-1:0] field_reg,     field_next;
    logic signed [FW-1:0] name_reg,      name_next;
    logic [NW-1:0]        value_cnt_reg, value_cnt_next;
    logic [NW-1:0]        name_cnt_reg,  name_cnt_next;
    logic [3:0][SW-1:0]   cols_reg,      cols_next;
    logic [PW-1:0]        pos_reg,       pos_next;
    logic [2:0]           err_reg,       err_next;

    logic [7:0]    ob;
    logic [2:0]    kind;
    logic [PW-1:0] offset;
    logic [SW-1:0] scols;

    logic signed [31:0] col_ext;
    logic signed [31:0] field_ext;
    logic signed [31:0] name_ext;
    logic [31:0]        off_ext;
    logic [31:0]        vcnt_ext;
    logic [31:0]        ncnt_ext;
    logic [31:0]        scols_ext;

    always_comb begin
        stream_next    = stream_reg;
        column_next    = column_reg;
        field_next     = field_reg;
        name_next      = name_reg;
        value_cnt_next = value_cnt_reg;
        name_cnt_next  = name_cnt_reg;
        cols_next      = cols_reg;
        pos_next       = pos_reg;
        err_next       = err_reg;
        ob             = item.in_byte;
        kind           = sst_pkg::EV_IGNORED;
        offset         = '0;

        if (pos_reg >= PW'(MAX_BUFFER_BYTES)) begin
            if (err_reg == sst_pkg::ERR_NONE) begin
                err_next = sst_pkg::ERR_TARGET;
            end
        end else begin
            pos_next = pos_reg + 1'b1;
            // once an error is held the index state stays frozen; only the byte position advances
            if (err_reg == sst_pkg::ERR_NONE) begin
                case (dec.cls)
                    sst_pkg::CLS_DATA: begin
                        kind = sst_pkg::EV_DATA;
                    end
                    sst_pkg::CLS_END: begin
                        kind = sst_pkg::EV_END;
                    end
                    sst_pkg::CLS_UNKNOWN: begin
                        err_next = sst_pkg::ERR_UNKNOWN;
                    end
                    sst_pkg::CLS_VALUE, sst_pkg::CLS_NAME: begin
                        if ((stream_reg == sst_pkg::NO_STREAM) || column_reg[CW-1]) begin
                            err_next = sst_pkg::ERR_TARGET;
                        end else begin
                            ob     = '0;
                            offset = pos_reg + 1'b1;
                            if (dec.cls == sst_pkg::CLS_VALUE) begin
                                kind           = sst_pkg::EV_VALUE;
                                value_cnt_next = value_cnt_reg + 1'b1;
                                field_next     = field_reg + 1'b1;
                                if (field_reg == FW'(MAX_FIELDS - 1)) begin
                                    err_next = sst_pkg::ERR_FIELDS;
                                end
                            end else begin
                                kind          = sst_pkg::EV_NAME;
                                name_cnt_next = name_cnt_reg + 1'b1;
                                name_next     = name_reg + 1'b1;
                                if (name_reg == FW'(MAX_FIELDS - 1)) begin
                                    err_next = sst_pkg::ERR_NAMES;
                                end
                            end
                        end
                    end
                    sst_pkg::CLS_COLUMN: begin
                        if (column_reg == CW'(MAX_COLUMNS - 1)) begin
                            err_next = sst_pkg::ERR_COLUMNS;
                        end else begin
                            ob             = '0;
                            kind           = sst_pkg::EV_COLUMN;
                            column_next    = column_reg + 1'b1;
                            field_next     = '0;
                            name_next      = '0;
                            value_cnt_next = '0;
                            name_cnt_next  = '0;
                            // per-stream count saturates, it survives reselection
                            if ((stream_reg != sst_pkg::NO_STREAM) &&
                                (cols_reg[stream_reg[1:0]] != SW'(MAX_COLUMNS))) begin
                                cols_next[stream_reg[1:0]] = cols_reg[stream_reg[1:0]] + 1'b1;
                            end
                        end
                    end
                    sst_pkg::CLS_STREAM: begin
                        ob             = '0;
                        kind           = sst_pkg::EV_STREAM;
                        stream_next    = {1'b0, dec.stream};
                        column_next    = '1;
                        field_next     = '1;
                        name_next      = '1;
                        value_cnt_next = '0;
                        name_cnt_next  = '0;
                    end
                    default: begin
                        kind = sst_pkg::EV_IGNORED;
                    end
                endcase
            end
        end
    end

    always_comb begin
        scols     = (stream_next == sst_pkg::NO_STREAM) ? '0 : cols_next[stream_next[1:0]];
        col_ext   = 32'(column_next);
        field_ext = 32'(field_next);
        name_ext  = 32'(name_next);
        off_ext   = 32'(offset);
        vcnt_ext  = 32'(value_cnt_next);
        ncnt_ext  = 32'(name_cnt_next);
        scols_ext = 32'(scols);

        res.out_byte       = ob;
        res.event_kind     = kind;
        res.cur_stream     = stream_next;
        res.cur_column     = col_ext[6:0];
        res.cur_field      = field_ext[7:0];
        res.cur_name       = name_ext[7:0];
        res.text_offset    = off_ext[16:0];
        res.value_count    = vcnt_ext[6:0];
        res.name_count     = ncnt_ext[6:0];
        res.stream_columns = scols_ext[6:0];
        res.error_code     = err_next;
        res.out_last       = item.last_byte;
    end

    // the last byte of a buffer returns everything to the reset state
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && item.last_byte)) begin
            stream_reg    <= sst_pkg::NO_STREAM;
            column_reg    <= '1;
            field_reg     <= '1;
            name_reg      <= '1;
            value_cnt_reg <= '0;
            name_cnt_reg  <= '0;
            cols_reg      <= '0;
            pos_reg       <= '0;
            err_reg       <= sst_pkg::ERR_NONE;
        end else if (step) begin
            stream_reg    <= stream_next;
            column_reg    <= column_next;
            field_reg     <= field_next;
            name_reg      <= name_next;
            value_cnt_reg <= value_cnt_next;
            name_cnt_reg  <= name_cnt_next;
            cols_reg      <= cols_next;
            pos_reg       <= pos_next;
            err_reg       <= err_next;
        end
    end

endmodule

[hdl/separator_stream_tokenizer_core.sv]
// channel   direction  handshake          payload
// s_        in         s_tvalid/s_tready  s_tdata in_byte, s_tlast last_byte
// m_        out        m_tvalid/m_tready  m_tdata result fields, m_tuser event_kind,
//                                         m_tlast out_last
// cfg_      in         cfg_valid/cfg_ready cfg_index register index, cfg_data value
//
// one byte per cycle sustained while m_tready allows; m_tvalid follows the s_ transaction
// through the input register, then decode and index update into the result register
// index state is updated in the same cycle the result register loads
// synchronous active-low reset empties both registers and clears all index state;
// codes return to their defaults
// m_tready low holds the result; the input register still takes one more byte
module separator_stream_tokenizer_core #(
    parameter int MAX_FIELDS       = 64,
    parameter int MAX_COLUMNS      = 64,
    parameter int MAX_BUFFER_BYTES = 65536
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] in_byte
    input  logic                            s_tlast,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] out_byte, [10:8] cur_stream, [17:11] cur_column, [25:18] cur_field,
    // [33:26] cur_name, [50:34] text_offset, [57:51] value_count,
    // [64:58] name_count, [71:65] stream_columns, [74:72] error_code, [79:75] zero
    output logic [sst_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic [2:0]                      m_tuser,   // [2:0] event_kind
    output logic                            m_tlast,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);

    sst_pkg::codes_t codes;
    sst_pkg::dec_t   dec;
    sst_pkg::res_t   res;

    sst_pkg::item_t  item_reg, item_next;
    logic            in_valid_reg, in_valid_next;
    sst_pkg::res_t   res_reg, res_next;
    logic            out_valid_reg, out_valid_next;

    logic            advance;
    logic            take_in;

    sst_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .codes     (codes)
    );

    sst_decode u_decode (
        .in_byte (item_reg.in_byte),
        .codes   (codes),
        .dec     (dec)
    );

    sst_track #(
        .MAX_FIELDS       (MAX_FIELDS),
        .MAX_COLUMNS      (MAX_COLUMNS),
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .dec     (dec),
        .res     (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = take_in || (in_valid_reg && !advance);
        item_next      = take_in ? {s_tdata, s_tlast} : item_reg;
        out_valid_next = advance || (out_valid_reg && !m_tready);
        res_next       = advance ? res : res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.event_kind;
    assign m_tlast  = res_reg.out_last;
    assign m_tdata  = {5'd0,
                       res_reg.error_code,
                       res_reg.stream_columns,
                       res_reg.name_count,
                       res_reg.value_count,
                       res_reg.text_offset,
                       res_reg.cur_name,
                       res_reg.cur_field,
                       res_reg.cur_column,
                       res_reg.cur_stream,
                       res_reg.out_byte};

endmodule

[hdl/sst_checker.sv]
module sst_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sst_pkg::TDATA_OUT_W-1:0] m_tdata,
    input logic [2:0]                      m_tuser,
    input logic                            m_tlast
);

    // a stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // separators that were acted on come out as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == sst_pkg::EV_VALUE || m_tuser == sst_pkg::EV_NAME ||
                     m_tuser == sst_pkg::EV_COLUMN || m_tuser == sst_pkg::EV_STREAM)
        |-> m_tdata[7:0] == 8'd0)
        else $error("separator byte not zeroed");

    // text offset only on value or name starts, and never zero there
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == sst_pkg::EV_VALUE || m_tuser == sst_pkg::EV_NAME)
                      == (m_tdata[50:34] != 17'd0)))
        else $error("text offset does not match event kind");

endmodule

bind separator_stream_tokenizer_core sst_checker u_sst_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_FIELDS       = 64;
    localparam int MAX_COLUMNS      = 64;
    localparam int MAX_BUFFER_BYTES = 65536;
    localparam logic [sst_pkg::CFG_IDX_W-1:0] NO_SUCH_REG = 4'd15;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata = '0;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [sst_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic [2:0]                      m_tuser;
    logic                            m_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [sst_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [7:0]                      cfg_data = '0;

    separator_stream_tokenizer_core #(
        .MAX_FIELDS      (MAX_FIELDS),
        .MAX_COLUMNS     (MAX_COLUMNS),
        .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the code registers and the tokenizer index state
    logic [7:0] code_reg [sst_pkg::NUM_REGS];
    logic [2:0] sel_stream;
    int         col_index;
    int         fld_index;
    int         nam_index;
    int         val_count;
    int         nam_count;
    int         stream_cols [4];
    int         buf_pos;
    logic [2:0] err_state;

    sst_pkg::item_t byte_queue [$];
    sst_pkg::res_t  expected_tokens [$];
    logic [7:0]     build_seq [$];

    int   issued_bytes = 0;
    int   matched_results = 0;
    int   mismatch_count = 0;
    int   generated = 0;
    logic no_gaps = 1'b0;

    task automatic reset_index_state();
        int i;
        sel_stream = sst_pkg::NO_STREAM;
        col_index  = -1;
        fld_index  = -1;
        nam_index  = -1;
        val_count  = 0;
        nam_count  = 0;
        for (i = 0; i < 4; i++) stream_cols[i] = 0;
        buf_pos    = 0;
        err_state  = sst_pkg::ERR_NONE;
    endtask

    task automatic flag_error(input logic [2:0] code);
        if (err_state == sst_pkg::ERR_NONE) err_state = code;
    endtask

    task automatic tokenize_byte(input logic [7:0] b, input logic last);
        sst_pkg::res_t r;
        int            hit;
        int            offs;
        int            i;
        logic [7:0]    ob;
        logic [2:0]    kind;
        ob   = b;
        kind = sst_pkg::EV_IGNORED;
        offs = 0;
        hit  = -1;
        if (buf_pos >= MAX_BUFFER_BYTES) begin
            flag_error(sst_pkg::ERR_TARGET);
        end else begin
            if (err_state == sst_pkg::ERR_NONE) begin
                // lowest register index wins when codes coincide
                for (i = sst_pkg::NUM_REGS - 1; i >= 0; i--)
                    if (code_reg[i] == b) hit = i;
                if (hit < 0) begin
                    if (b >= code_reg[sst_pkg::REG_END] && b <= code_reg[sst_pkg::REG_ENVIR])
                        flag_error(sst_pkg::ERR_UNKNOWN);
                    else
                        kind = sst_pkg::EV_DATA;
                end else if (hit == sst_pkg::REG_END) begin
                    kind = sst_pkg::EV_END;
                end else if (hit == sst_pkg::REG_VALUE || hit == sst_pkg::REG_NAME) begin
                    if (sel_stream == sst_pkg::NO_STREAM || col_index < 0) begin
                        flag_error(sst_pkg::ERR_TARGET);
                    end else begin
                        ob   = '0;
                        offs = buf_pos + 1;
                        if (hit == sst_pkg::REG_VALUE) begin
                            kind = sst_pkg::EV_VALUE;
                            val_count++;
                            fld_index++;
                            if (fld_index >= MAX_FIELDS) flag_error(sst_pkg::ERR_FIELDS);
                        end else begin
                            kind = sst_pkg::EV_NAME;
                            nam_count++;
                            nam_index++;
                            if (nam_index >= MAX_FIELDS) flag_error(sst_pkg::ERR_NAMES);
                        end
                    end
                end else if (hit == sst_pkg::REG_COLUMN) begin
                    if (col_index + 1 >= MAX_COLUMNS) begin
                        flag_error(sst_pkg::ERR_COLUMNS);
                    end else begin
                        ob        = '0;
                        kind      = sst_pkg::EV_COLUMN;
                        col_index++;
                        fld_index = 0;
                        nam_index = 0;
                        val_count = 0;
                        nam_count = 0;
                        if (sel_stream != sst_pkg::NO_STREAM &&
                            stream_cols[sel_stream[1:0]] < MAX_COLUMNS)
                            stream_cols[sel_stream[1:0]]++;
                    end
                end else begin
                    ob         = '0;
                    kind       = sst_pkg::EV_STREAM;
                    sel_stream = 3'(hit - int'(sst_pkg::REG_STDOUT));
                    col_index  = -1;
                    fld_index  = -1;
                    nam_index  = -1;
                    val_count  = 0;
                    nam_count  = 0;
                end
            end
            buf_pos++;
        end
        r.out_byte       = ob;
        r.event_kind     = kind;
        r.cur_stream     = sel_stream;
        r.cur_column     = 7'(col_index);
        r.cur_field      = 8'(fld_index);
        r.cur_name       = 8'(nam_index);
        r.text_offset    = 17'(offs);
        r.value_count    = 7'(val_count);
        r.name_count     = 7'(nam_count);
        r.stream_columns = (sel_stream != sst_pkg::NO_STREAM) ?
                           7'(stream_cols[sel_stream[1:0]]) : 7'd0;
        r.error_code     = err_state;
        r.out_last       = last;
        expected_tokens.push_back(r);
        if (last) reset_index_state();
    endtask

    // byte source: may load a new transaction when the slot is free, with random gaps unless no_gaps
    always @(posedge aclk) begin : byte_driver
        sst_pkg::item_t nxt;
        logic           go;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) tokenize_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                go = (byte_queue.size() != 0) && (no_gaps || $urandom_range(99) >= 9);
                if (go) begin
                    nxt = byte_queue.pop_front();
                    issued_bytes++;
                    s_tdata <= nxt.in_byte;
                    s_tlast <= nxt.last_byte;
                end
                s_tvalid <= go;
            end
        end
    end

    task automatic check_field(input string what, input logic [16:0] want,
                               input logic [16:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : token_monitor
        sst_pkg::res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result expected none actual %0h",
                             $time, m_tdata);
                end else begin
                    want = expected_tokens.pop_front();
                    matched_results++;
                    check_field("out_byte", 17'(want.out_byte), 17'(m_tdata[7:0]));
                    check_field("cur_stream", 17'(want.cur_stream), 17'(m_tdata[10:8]));
                    check_field("cur_column", 17'(want.cur_column), 17'(m_tdata[17:11]));
                    check_field("cur_field", 17'(want.cur_field), 17'(m_tdata[25:18]));
                    check_field("cur_name", 17'(want.cur_name), 17'(m_tdata[33:26]));
                    check_field("text_offset", want.text_offset, m_tdata[50:34]);
                    check_field("value_count", 17'(want.value_count), 17'(m_tdata[57:51]));
                    check_field("name_count", 17'(want.name_count), 17'(m_tdata[64:58]));
                    check_field("stream_columns", 17'(want.stream_columns),
                                17'(m_tdata[71:65]));
                    check_field("error_code", 17'(want.error_code), 17'(m_tdata[74:72]));
                    check_field("event_kind", 17'(want.event_kind), 17'(m_tuser));
                    check_field("out_last", 17'(want.out_last), 17'(m_tlast));
                end
            end
            m_tready <= no_gaps || ($urandom_range(99) >= 9);
        end
    end

    function automatic logic is_special(input logic [7:0] b);
        int   i;
        logic hitf;
        hitf = (b >= code_reg[sst_pkg::REG_END] && b <= code_reg[sst_pkg::REG_ENVIR]);
        for (i = 0; i < sst_pkg::NUM_REGS; i++)
            if (code_reg[i] == b) hitf = 1'b1;
        return hitf;
    endfunction

    // plain text byte where the code layout leaves room for one
    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        int         k;
        b = 8'($urandom_range(255));
        for (k = 0; k < 8 && is_special(b); k++) b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic logic [7:0] unknown_byte();
        if (code_reg[sst_pkg::REG_END] <= code_reg[sst_pkg::REG_ENVIR])
            return 8'($urandom_range(code_reg[sst_pkg::REG_ENVIR],
                                     code_reg[sst_pkg::REG_END]));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] stream_byte(input int s);
        return code_reg[int'(sst_pkg::REG_STDOUT) + s];
    endfunction

    function automatic logic [7:0] any_byte();
        case ($urandom_range(7))
            0:       return data_byte();
            1:       return code_reg[sst_pkg::REG_END];
            2:       return code_reg[sst_pkg::REG_VALUE];
            3:       return code_reg[sst_pkg::REG_NAME];
            4:       return code_reg[sst_pkg::REG_COLUMN];
            5:       return stream_byte($urandom_range(3));
            6:       return unknown_byte();
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // queue the assembled buffer, marking its final byte
    task automatic flush_buffer();
        sst_pkg::item_t it;
        int             k;
        for (k = 0; k < build_seq.size(); k++) begin
            it.in_byte   = build_seq[k];
            it.last_byte = (k == build_seq.size() - 1);
            byte_queue.push_back(it);
        end
        generated += build_seq.size();
        build_seq.delete();
    endtask

    task automatic gen_buffer();
        int         mode;
        int         n;
        int         j;
        int         t;
        int         s;
        int         k;
        logic [7:0] fb;
        mode = $urandom_range(99);
        if (mode < 55) begin
            // ordinary layout: streams, columns, fields with text
            for (n = $urandom_range(1, 3); n > 0; n--) begin
                build_seq.push_back(stream_byte($urandom_range(3)));
                if ($urandom_range(9) != 0) begin
                    for (j = $urandom_range(1, 4); j > 0; j--) begin
                        build_seq.push_back(code_reg[sst_pkg::REG_COLUMN]);
                        for (t = $urandom_range(0, 5); t > 0; t--) begin
                            build_seq.push_back($urandom_range(1) ?
                                                code_reg[sst_pkg::REG_VALUE] :
                                                code_reg[sst_pkg::REG_NAME]);
                            for (s = $urandom_range(0, 3); s > 0; s--)
                                build_seq.push_back(data_byte());
                            if ($urandom_range(15) == 0)
                                build_seq.push_back(code_reg[sst_pkg::REG_END]);
                        end
                    end
                end
            end
            if ($urandom_range(1)) build_seq.push_back(data_byte());
        end else if (mode < 63) begin
            // one column crowded with values or names around the field limit
            build_seq.push_back(stream_byte($urandom_range(3)));
            build_seq.push_back(code_reg[sst_pkg::REG_COLUMN]);
            fb = $urandom_range(1) ? code_reg[sst_pkg::REG_VALUE] : code_reg[sst_pkg::REG_NAME];
            for (n = $urandom_range(58, 68); n > 0; n--) begin
                build_seq.push_back(fb);
                if ($urandom_range(7) == 0) build_seq.push_back(data_byte());
            end
        end else if (mode < 68) begin
            // column index runs up to or into the column limit
            build_seq.push_back(stream_byte($urandom_range(3)));
            for (n = $urandom_range(58, 68); n > 0; n--) begin
                build_seq.push_back(code_reg[sst_pkg::REG_COLUMN]);
                if ($urandom_range(3) == 0) build_seq.push_back(code_reg[sst_pkg::REG_VALUE]);
            end
        end else if (mode < 71) begin
            // reselect a stream so its column count can saturate
            s = $urandom_range(3);
            build_seq.push_back(stream_byte(s));
            for (n = $urandom_range(35, 50); n > 0; n--)
                build_seq.push_back(code_reg[sst_pkg::REG_COLUMN]);
            build_seq.push_back(stream_byte((s + 1) % 4));
            build_seq.push_back(code_reg[sst_pkg::REG_COLUMN]);
            build_seq.push_back(stream_byte(s));
            for (n = $urandom_range(20, 32); n > 0; n--)
                build_seq.push_back(code_reg[sst_pkg::REG_COLUMN]);
            build_seq.push_back(code_reg[sst_pkg::REG_NAME]);
        end else if (mode < 86) begin
            for (k = $urandom_range(2, 12); k > 0; k--) build_seq.push_back(any_byte());
        end else begin
            for (k = $urandom_range(1, 16); k > 0; k--)
                build_seq.push_back(8'($urandom_range(255)));
        end
        flush_buffer();
    endtask

    task automatic drain();
        while (byte_queue.size() != 0 || issued_bytes != matched_results)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_random(input int target);
        generated = 0;
        while (generated < target) gen_buffer();
        drain();
    endtask

    // caller lowers cfg_valid after its last write
    task automatic write_code(input logic [sst_pkg::CFG_IDX_W-1:0] idx,
                              input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < sst_pkg::NUM_REGS) code_reg[idx[sst_pkg::REG_IDX_W-1:0]] = val;
    endtask

    task automatic load_codes(input sst_pkg::codes_t c);
        int                            i;
        logic [sst_pkg::CFG_IDX_W-1:0] idx;
        for (i = 0; i < sst_pkg::NUM_REGS; i++) begin
            idx = sst_pkg::CFG_IDX_W'(i);
            write_code(idx, c[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        sst_pkg::codes_t c;
        int              i;
        for (i = 0; i < sst_pkg::NUM_REGS; i++) code_reg[i] = sst_pkg::CODES_RESET[i];
        reset_index_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default codes: every event kind, extremes of the byte, no-target cases
        build_seq = '{8'h00, 8'hFF, code_reg[sst_pkg::REG_END], code_reg[sst_pkg::REG_STDOUT],
                      code_reg[sst_pkg::REG_COLUMN], code_reg[sst_pkg::REG_VALUE], 8'h41,
                      code_reg[sst_pkg::REG_NAME], 8'h42, code_reg[sst_pkg::REG_COLUMN],
                      code_reg[sst_pkg::REG_STDERR], code_reg[sst_pkg::REG_COLUMN],
                      code_reg[sst_pkg::REG_OUTPUT], code_reg[sst_pkg::REG_ENVIR],
                      code_reg[sst_pkg::REG_COLUMN], code_reg[sst_pkg::REG_VALUE]};
        flush_buffer();
        build_seq = '{code_reg[sst_pkg::REG_NAME], 8'h30, 8'h31};
        flush_buffer();
        build_seq = '{code_reg[sst_pkg::REG_STDOUT], code_reg[sst_pkg::REG_VALUE]};
        flush_buffer();
        run_random(160);

        // spread codes leave unassigned values inside the code range
        c[sst_pkg::REG_END] = 8'h10; c[sst_pkg::REG_VALUE] = 8'h20;
        c[sst_pkg::REG_NAME] = 8'h30; c[sst_pkg::REG_COLUMN] = 8'h40;
        c[sst_pkg::REG_STDOUT] = 8'h50; c[sst_pkg::REG_STDERR] = 8'h60;
        c[sst_pkg::REG_OUTPUT] = 8'h70; c[sst_pkg::REG_ENVIR] = 8'h80;
        load_codes(c);
        build_seq = '{code_reg[sst_pkg::REG_STDOUT], 8'h15, 8'h99};
        flush_buffer();
        run_random(90);

        // full byte range: no plain data exists
        c[sst_pkg::REG_END] = 8'h00; c[sst_pkg::REG_VALUE] = 8'hFE;
        c[sst_pkg::REG_NAME] = 8'h80; c[sst_pkg::REG_COLUMN] = 8'h7F;
        c[sst_pkg::REG_STDOUT] = 8'h01; c[sst_pkg::REG_STDERR] = 8'h40;
        c[sst_pkg::REG_OUTPUT] = 8'hC0; c[sst_pkg::REG_ENVIR] = 8'hFF;
        load_codes(c);
        run_random(60);

        // inverted bounds: unknown range is empty
        c[sst_pkg::REG_END] = 8'hFF; c[sst_pkg::REG_VALUE] = 8'h2C;
        c[sst_pkg::REG_NAME] = 8'h3A; c[sst_pkg::REG_COLUMN] = 8'h0A;
        c[sst_pkg::REG_STDOUT] = 8'h31; c[sst_pkg::REG_STDERR] = 8'h32;
        c[sst_pkg::REG_OUTPUT] = 8'h33; c[sst_pkg::REG_ENVIR] = 8'h00;
        load_codes(c);
        run_random(70);

        // shared codes: the lower register shadows the higher one
        c[sst_pkg::REG_END] = 8'h10; c[sst_pkg::REG_VALUE] = 8'h11;
        c[sst_pkg::REG_NAME] = 8'h11; c[sst_pkg::REG_COLUMN] = 8'h12;
        c[sst_pkg::REG_STDOUT] = 8'h13; c[sst_pkg::REG_STDERR] = 8'h13;
        c[sst_pkg::REG_OUTPUT] = 8'h12; c[sst_pkg::REG_ENVIR] = 8'h20;
        load_codes(c);
        run_random(70);

        write_code(NO_SUCH_REG, 8'h5A);
        for (i = 0; i < sst_pkg::NUM_REGS; i++) c[i] = 8'($urandom_range(255));
        load_codes(c);
        run_random(100);

        // default codes again with no idling on either side
        load_codes(sst_pkg::CODES_RESET);
        no_gaps = 1'b1;
        run_random(70);
        no_gaps = 1'b0;
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0 && expected_tokens.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
